>>> hdl/xref_stream_entry_decoder_core_macros.svh
// Assertion macros for the cross-reference stream entry decoder.
// Define NO_ASSERTIONS to compile every check away.
`ifndef XREF_STREAM_ENTRY_DECODER_CORE_MACROS_SVH
`define XREF_STREAM_ENTRY_DECODER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset only.
`define XSED_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("xsed check failed");
// Checked at every edge, reset included.
`define XSED_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) else $error("xsed check failed");
`else
`define XSED_ASSERT(label, prop)
`define XSED_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> hdl/xsed_pkg.sv
// Shared types, constants and helpers of the cross-reference stream entry decoder.
// No dependencies.
`timescale 1ns / 1ps
package xsed_pkg;
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int MAX_FIELD_BYTES = 8;
	localparam int OUTQ_DEPTH = 3;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	localparam logic OP_SECTION = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	localparam logic [1:0] REG_TYPE_WIDTH = 2'd0;
	localparam logic [1:0] REG_LOCATION_WIDTH = 2'd1;
	localparam logic [1:0] REG_THIRD_WIDTH = 2'd2;

	typedef enum logic [1:0] {
		KIND_FREE = 2'd0,
		KIND_IN_USE = 2'd1,
		KIND_COMPRESSED = 2'd2
	} kind_t;

	typedef struct packed {
		logic [3:0] type_width;
		logic [3:0] location_width;
		logic [3:0] third_width;
	} widths_t;

	typedef struct packed {
		logic [30:0] object_number;
		kind_t entry_kind;
		logic [63:0] location;
		logic [31:0] gen_or_index;
		logic beyond_table;
	} entry_t;

	typedef struct packed {
		logic clearing;
		logic s1_valid;
	} seen_status_t;

	typedef struct packed {
		logic [OUTQ_CNT_W-1:0] count;
		logic full;
	} outq_status_t;

	// Clamp a register width to the widest field supported.
	function automatic logic [3:0] eff_width(input logic [3:0] w);
		eff_width = (w > 4'(MAX_FIELD_BYTES)) ? 4'(MAX_FIELD_BYTES) : w;
	endfunction
endpackage

>>> hdl/xsed_asm.sv
// Entry assembler: section tracking, big-endian field accumulation, classification.
// Depends on xsed_pkg.
`timescale 1ns / 1ps
module xsed_asm (
	input  logic                clk,
	input  logic                arst_n,
	input  xsed_pkg::widths_t   widths,
	input  logic                in_valid,
	input  logic                opcode,
	input  logic [30:0]         section_first,
	input  logic [30:0]         section_count,
	input  logic [7:0]          data_byte,
	output logic                ent_valid,
	output xsed_pkg::entry_t    ent,
	output logic [xsed_pkg::IDX_W-1:0] ent_addr
);
	import xsed_pkg::*;

	logic [63:0] type_q, loc_q, third_q;
	logic [4:0]  bie_q;
	logic [30:0] next_obj_q, left_q;

	logic [3:0]  tw, lw, gw;
	logic [4:0]  size, bie_n;
	logic        byte_ok, done;
	logic [63:0] type_n, loc_n, third_n, type_v, third_v;

	always_comb begin
		tw = eff_width(widths.type_width);
		lw = eff_width(widths.location_width);
		gw = eff_width(widths.third_width);
		size = 5'(tw) + 5'(lw) + 5'(gw);
		byte_ok = in_valid && (opcode == OP_BYTE) && (left_q != 31'd0) && (size != 5'd0);
		type_n = type_q;
		loc_n = loc_q;
		third_n = third_q;
		if (bie_q < 5'(tw)) begin
			type_n = {type_q[55:0], data_byte};
		end else if (bie_q < 5'(tw) + 5'(lw)) begin
			loc_n = {loc_q[55:0], data_byte};
		end else if (bie_q < size) begin
			third_n = {third_q[55:0], data_byte};
		end
		bie_n = bie_q + 5'd1;
		done = byte_ok && (bie_n >= size);
		type_v = (tw != 4'd0) ? type_n : 64'd1;
		third_v = (gw != 4'd0) ? third_n : 64'd0;
	end

	always_comb begin
		ent.object_number = next_obj_q;
		ent.entry_kind = KIND_FREE;
		ent.location = 64'd0;
		ent.gen_or_index = 32'd0;
		ent.beyond_table = (next_obj_q >= 31'(TABLE_DEPTH));
		if (type_v == 64'd1) begin
			ent.entry_kind = KIND_IN_USE;
			ent.location = loc_n;
			ent.gen_or_index = third_v[31:0];
		end else if (type_v == 64'd2) begin
			ent.entry_kind = KIND_COMPRESSED;
			ent.location = {32'd0, loc_n[31:0]};
			ent.gen_or_index = third_v[31:0];
		end
	end

	assign ent_valid = done;
	assign ent_addr = next_obj_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= 64'd0;
			loc_q <= 64'd0;
			third_q <= 64'd0;
			bie_q <= 5'd0;
			next_obj_q <= 31'd0;
			left_q <= 31'd0;
		end else if (in_valid && (opcode == OP_SECTION)) begin
			// New section: drop any partial entry.
			next_obj_q <= section_first;
			left_q <= section_count;
			type_q <= 64'd0;
			loc_q <= 64'd0;
			third_q <= 64'd0;
			bie_q <= 5'd0;
		end else if (done) begin
			next_obj_q <= next_obj_q + 31'd1;
			left_q <= left_q - 31'd1;
			type_q <= 64'd0;
			loc_q <= 64'd0;
			third_q <= 64'd0;
			bie_q <= 5'd0;
		end else if (byte_ok) begin
			type_q <= type_n;
			loc_q <= loc_n;
			third_q <= third_n;
			bie_q <= bie_n;
		end
	end
endmodule

>>> hdl/xsed_seen.sv
// Seen-bitmap stage: one-bit table memory, read-modify-write with forwarding,
// clearing pass after reset. Depends on xsed_pkg.
`timescale 1ns / 1ps
module xsed_seen (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ent_valid,
	input  xsed_pkg::entry_t    ent,
	input  logic [xsed_pkg::IDX_W-1:0] ent_addr,
	output logic                push,
	output xsed_pkg::entry_t    push_entry,
	output xsed_pkg::seen_status_t status
);
	import xsed_pkg::*;

	logic             mem [TABLE_DEPTH];
	logic             rd_q;
	logic             fwd_s1;
	logic             s1_valid_q;
	entry_t           entry_s1;
	logic [IDX_W-1:0] addr_s1;
	logic             clearing_q;
	logic [IDX_W-1:0] clear_idx_q;

	logic             seen, s1_wr, wr_en, wr_bit;
	logic [IDX_W-1:0] wr_addr;

	always_comb begin
		seen = rd_q | fwd_s1;
		s1_wr = s1_valid_q && !entry_s1.beyond_table && !seen;
		push = s1_valid_q && (entry_s1.beyond_table || !seen);
		wr_en = clearing_q || s1_wr;
		wr_addr = clearing_q ? clear_idx_q : addr_s1;
		wr_bit = !clearing_q;
	end

	assign push_entry = entry_s1;
	assign status.clearing = clearing_q;
	assign status.s1_valid = s1_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_bit;
		end
		rd_q <= mem[ent_addr];
		// Cover a write landing on the same edge as the read.
		fwd_s1 <= s1_wr && (addr_s1 == ent_addr);
		entry_s1 <= ent;
		addr_s1 <= ent_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			clearing_q <= 1'b1;
			clear_idx_q <= '0;
		end else begin
			s1_valid_q <= ent_valid;
			if (clearing_q) begin
				clear_idx_q <= clear_idx_q + IDX_W'(1);
				if (clear_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end
endmodule

>>> hdl/xsed_outq.sv
// Output queue: small circular buffer between the bitmap stage and the result channel.
// Depends on xsed_pkg.
`timescale 1ns / 1ps
module xsed_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  xsed_pkg::entry_t    push_entry,
	input  logic                pop_ready,
	output logic                head_valid,
	output xsed_pkg::entry_t    head,
	output xsed_pkg::outq_status_t status
);
	import xsed_pkg::*;

	entry_t                q_mem [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUTQ_CNT_W-1:0] cnt_q;
	logic                  pop;

	function automatic logic [OUTQ_PTR_W-1:0] ptr_inc(input logic [OUTQ_PTR_W-1:0] p);
		ptr_inc = (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + OUTQ_PTR_W'(1);
	endfunction

	assign head_valid = (cnt_q != '0);
	assign head = q_mem[rd_ptr_q];
	assign pop = head_valid && pop_ready;
	assign status.count = cnt_q;
	assign status.full = (cnt_q == OUTQ_CNT_W'(OUTQ_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + OUTQ_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - OUTQ_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

>>> hdl/xref_stream_entry_decoder_core.sv
// Top level of the cross-reference stream entry decoder: stream ports, width registers.
// Depends on xsed_pkg, xsed_asm, xsed_seen, xsed_outq and the assertion macro header.
`timescale 1ns / 1ps
`include "xref_stream_entry_decoder_core_macros.svh"
// Cross-reference stream entry decoder. Feed section starts (tuser = 0) and decoded
// stream bytes (tuser = 1) on the slave side; each completed entry whose object number
// is seen for the first time leaves on the master side as one beat (numbers at or past
// the 4096-entry table always leave, flagged beyond_table, and are never recorded).
// Throughput is one input beat per clock while s_tready is high. An entry's last byte
// reads the seen bitmap at the edge it is accepted; the next cycle checks the bit and
// writes it back, and a same-edge write to the same number is forwarded, so the result
// passes from the bitmap stage register into the output queue and m_tvalid rises with
// the edge that writes it there.
// A three-deep output queue lets input continue while a result waits; outside the
// sweep, s_tready drops only when the queue plus the bitmap stage could overflow.
// After reset the bitmap is swept to zero, one entry a cycle, across the whole table;
// s_tready stays low meanwhile, while width writes are taken at any time.
module xref_stream_entry_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	// Width registers.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	// Input beats.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // section_first[30:0], section_count[61:31],
	                               // data_byte[69:62], zero [71:70]
	input  logic        s_tuser,   // opcode: 0 section start, 1 stream byte
	// Result beats.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [127:0] m_tdata,  // object_number[30:0], location[94:31],
	                               // gen_or_index[126:95], zero [127]
	output logic [2:0]  m_tuser    // entry_kind[1:0], beyond_table[2]
);
	import xsed_pkg::*;

	widths_t      widths_q;
	logic         in_valid;
	logic         ent_valid;
	entry_t       ent;
	logic [IDX_W-1:0] ent_addr;
	logic         q_push;
	entry_t       q_entry;
	entry_t       head;
	seen_status_t seen_st;
	outq_status_t q_st;
	logic [OUTQ_CNT_W:0] occupancy;

	// Width registers: write only, unknown indexes ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widths_q.type_width <= 4'd1;
			widths_q.location_width <= 4'd4;
			widths_q.third_width <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TYPE_WIDTH:     widths_q.type_width <= cfg_data;
				REG_LOCATION_WIDTH: widths_q.location_width <= cfg_data;
				REG_THIRD_WIDTH:    widths_q.third_width <= cfg_data;
				default:            widths_q <= widths_q;
			endcase
		end
	end

	// Hold input while the bitmap sweeps or while a new result might not fit.
	assign occupancy = (OUTQ_CNT_W + 1)'(q_st.count) + (OUTQ_CNT_W + 1)'(seen_st.s1_valid);
	assign s_tready = !seen_st.clearing && (occupancy < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
	assign in_valid = s_tvalid && s_tready;

	xsed_asm u_asm (
		.clk           (clk),
		.arst_n        (arst_n),
		.widths        (widths_q),
		.in_valid      (in_valid),
		.opcode        (s_tuser),
		.section_first (s_tdata[30:0]),
		.section_count (s_tdata[61:31]),
		.data_byte     (s_tdata[69:62]),
		.ent_valid     (ent_valid),
		.ent           (ent),
		.ent_addr      (ent_addr)
	);

	xsed_seen u_seen (
		.clk        (clk),
		.arst_n     (arst_n),
		.ent_valid  (ent_valid),
		.ent        (ent),
		.ent_addr   (ent_addr),
		.push       (q_push),
		.push_entry (q_entry),
		.status     (seen_st)
	);

	xsed_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop_ready  (m_tready),
		.head_valid (m_tvalid),
		.head       (head),
		.status     (q_st)
	);

	// Pack the result beat.
	assign m_tdata = {1'b0, head.gen_or_index, head.location, head.object_number};
	assign m_tuser = {head.beyond_table, 2'(head.entry_kind)};

	// No beat enters while the bitmap is being swept.
	`XSED_ASSERT(a_no_accept_in_sweep, seen_st.clearing |-> !s_tready)
	// The bitmap stage is empty during the sweep, so no lookup races a clearing write.
	`XSED_ASSERT(a_no_lookup_in_sweep, seen_st.clearing |-> !seen_st.s1_valid)
	// The ready rule leaves room for every result.
	`XSED_ASSERT(a_queue_room, q_push |-> !q_st.full)
endmodule
